[rtl/ecn_fraction_alpha_estimator_unit_assert.svh]
// Assertion macros shared by the ECN alpha estimator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ECN_FRACTION_ALPHA_ESTIMATOR_UNIT_ASSERT_SVH
`define ECN_FRACTION_ALPHA_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ECNFA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define ECNFA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ecnfa_pkg.sv]
// Shared types and constants of the ECN alpha estimator.
// No dependencies; used by every RTL module of the block.
package ecnfa_pkg;

	localparam int SEQ_W   = 32;
	localparam int WIN_W   = 20;
	localparam int ALPHA_W = 48;
	localparam int GAIN_W  = 4;
	localparam int OP_W    = 3;
	localparam int DIV_W   = 64;
	localparam int CNT_W   = 7;

	// Operation codes
	localparam logic [OP_W-1:0] OP_START = 3'd0;
	localparam logic [OP_W-1:0] OP_ACK   = 3'd1;
	localparam logic [OP_W-1:0] OP_ECN   = 3'd2;
	localparam logic [OP_W-1:0] OP_LOSS  = 3'd3;
	localparam logic [OP_W-1:0] OP_UNDO  = 3'd4;

	// Register map
	localparam logic REG_GAIN = 1'b0;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd4;

	localparam int FRAC_BITS = 31;
	localparam logic [WIN_W-1:0] MIN_WINDOW = 20'd2;
	localparam logic [CNT_W-1:0] DIV_SHORT_STEPS = 7'd32;
	localparam logic [CNT_W-1:0] DIV_LONG_STEPS  = 7'd64;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [SEQ_W-1:0] ack_seq;
		logic [SEQ_W-1:0] send_next;
		logic [SEQ_W-1:0] delivered_count;
		logic [SEQ_W-1:0] ce_count;
		logic [WIN_W-1:0] window_in;
	} in_req_t;

	typedef struct packed {
		logic [WIN_W-1:0]   window_out;
		logic [ALPHA_W-1:0] alpha_out;
		logic               round_ended;
	} out_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic shift;
		logic div_go;
		logic div_long;
		logic mul;
		logic acc;
		logic upd;
		logic red;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            mark_go;
		logic            round_hit;
		logic            marked_nz;
		logic            div_busy;
	} dp_sts_t;

endpackage

[rtl/ecn_fraction_alpha_estimator_unit.sv]
// Top level of the ECN alpha estimator: APB register, controller and datapath.
// Depends on ecnfa_pkg, ecnfa_ctrl, ecnfa_dp (and ecnfa_div below it).
//
//   channel | ports                          | payload
//   --------+--------------------------------+---------------------
//   in      | in_valid / in_stall            | in_data  (in_req_t)
//   out     | out_valid / out_stall          | out_data (out_rsp_t)
//   cfg     | psel penable pwrite paddr ...  | gain_shift at 0x0
//
// Start, loss, undo and unused codes go from execute to finish; ECN reduction
// adds a multiply and a reduce state. An ack may run the bit-serial divider:
// 32 steps for the bytes-per-packet quotient, 64 for the marked fraction.
// A new request is accepted once the previous result sits in the output
// register; a stalled output holds the controller in its final state.
// Reset asynchronously clears the control and connection state; gain_shift resets to 4.
module ecn_fraction_alpha_estimator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ecnfa_pkg::in_req_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ecnfa_pkg::out_rsp_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [ecnfa_pkg::GAIN_W-1:0] gain_q;
	logic                         reg_hit;
	ecnfa_pkg::dp_cmd_t           cmd;
	ecnfa_pkg::dp_sts_t           sts;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == ecnfa_pkg::REG_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ecnfa_pkg::GAIN_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			gain_q <= pwdata[ecnfa_pkg::GAIN_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(32-ecnfa_pkg::GAIN_W){1'b0}}, gain_q} : 32'd0;

	ecnfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ecnfa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain_shift (gain_q),
		.in_data    (in_data),
		.cmd        (cmd),
		.sts        (sts),
		.out_data   (out_data)
	);

endmodule

[rtl/ecnfa_div.sv]
// Restoring unsigned divider, one quotient bit per cycle (64 or 32 steps).
// Depends on ecnfa_pkg.
module ecnfa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        long_mode,
	input  logic [ecnfa_pkg::DIV_W-1:0] dividend,
	input  logic [ecnfa_pkg::SEQ_W-1:0] divisor,
	output logic                        busy,
	output logic [ecnfa_pkg::DIV_W-1:0] quotient
);

	logic [ecnfa_pkg::CNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic [ecnfa_pkg::SEQ_W-1:0] rem_q;
	logic [ecnfa_pkg::SEQ_W-1:0] dsr_q;
	logic [ecnfa_pkg::DIV_W-1:0] dq_q;

	logic [ecnfa_pkg::SEQ_W:0] trial;
	logic [ecnfa_pkg::SEQ_W:0] diff;
	logic                      ge;

	// One trial subtraction per step
	always_comb begin
		trial = {rem_q, dq_q[ecnfa_pkg::DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= long_mode ? ecnfa_pkg::DIV_LONG_STEPS : ecnfa_pkg::DIV_SHORT_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and shifting dividend/quotient word
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ecnfa_pkg::SEQ_W-1:0] : trial[ecnfa_pkg::SEQ_W-1:0];
			dq_q  <= {dq_q[ecnfa_pkg::DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

[rtl/ecnfa_dp.sv]
// Datapath: connection state, shared multiplier, divider and result register.
// Depends on ecnfa_pkg and ecnfa_div.
module ecnfa_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ecnfa_pkg::GAIN_W-1:0] gain_shift,
	input  ecnfa_pkg::in_req_t           in_data,
	input  ecnfa_pkg::dp_cmd_t           cmd,
	output ecnfa_pkg::dp_sts_t           sts,
	output ecnfa_pkg::out_rsp_t          out_data
);

	// Captured request
	logic [ecnfa_pkg::OP_W-1:0]  op_q;
	logic [ecnfa_pkg::SEQ_W-1:0] una_q;
	logic [ecnfa_pkg::SEQ_W-1:0] nxt_q;
	logic [ecnfa_pkg::SEQ_W-1:0] dlv_q;
	logic [ecnfa_pkg::SEQ_W-1:0] ce_q;
	logic [ecnfa_pkg::WIN_W-1:0] win_q;

	// Connection state
	logic [ecnfa_pkg::SEQ_W-1:0]   prior_ack_q;
	logic [ecnfa_pkg::SEQ_W-1:0]   base_dlv_q;
	logic [ecnfa_pkg::SEQ_W-1:0]   base_ce_q;
	logic [ecnfa_pkg::SEQ_W-1:0]   marked_q;
	logic [ecnfa_pkg::SEQ_W-1:0]   acked_total_q;
	logic [ecnfa_pkg::SEQ_W-1:0]   round_end_q;
	logic [ecnfa_pkg::ALPHA_W-1:0] alpha_q;
	logic [ecnfa_pkg::WIN_W-1:0]   loss_win_q;

	// Work registers
	logic [ecnfa_pkg::ALPHA_W-1:0] shr_q;
	logic [ecnfa_pkg::DIV_W-1:0]   prod_q;
	logic [ecnfa_pkg::WIN_W-1:0]   wout_q;
	logic                          ended_q;
	ecnfa_pkg::out_rsp_t           out_q;

	logic [ecnfa_pkg::SEQ_W-1:0] acked;
	logic [ecnfa_pkg::SEQ_W-1:0] d_pk;
	logic [ecnfa_pkg::SEQ_W-1:0] d_ce;
	logic [ecnfa_pkg::SEQ_W-1:0] una_rel;
	logic                        mark_go;

	logic [ecnfa_pkg::DIV_W-1:0] div_dividend;
	logic [ecnfa_pkg::SEQ_W-1:0] div_divisor;
	logic [ecnfa_pkg::DIV_W-1:0] quot;
	logic                        div_busy;

	logic [ecnfa_pkg::SEQ_W-1:0] mul_a;
	logic [ecnfa_pkg::SEQ_W-1:0] mul_b;
	logic [ecnfa_pkg::DIV_W-1:0] prod_c;

	logic [ecnfa_pkg::WIN_W-1:0] half_win;
	logic [ecnfa_pkg::WIN_W-1:0] loss_wout;
	logic [ecnfa_pkg::WIN_W-1:0] undo_wout;

	logic [52:0]                 red_sum;
	logic [ecnfa_pkg::WIN_W:0]   red;
	logic [ecnfa_pkg::WIN_W:0]   red_diff;
	logic                        red_floor;
	logic [ecnfa_pkg::WIN_W-1:0] ecn_wout;

	logic [ecnfa_pkg::ALPHA_W-1:0] decay;
	logic [ecnfa_pkg::DIV_W-1:0]   frac;
	logic [ecnfa_pkg::DIV_W:0]     alpha_sum;
	logic [ecnfa_pkg::ALPHA_W-1:0] alpha_next;

	// Per-ack deltas and round-end test
	always_comb begin
		acked   = una_q - prior_ack_q;
		d_pk    = dlv_q - base_dlv_q;
		d_ce    = ce_q - base_ce_q;
		una_rel = una_q - round_end_q;
		mark_go = (acked != '0) && (d_pk != '0) && (d_ce != '0);
	end

	// Divider operands: acked / d_pk, or (marked << 31) / max(1, total)
	always_comb begin
		if (cmd.div_long) begin
			div_dividend = {1'b0, marked_q, {ecnfa_pkg::FRAC_BITS{1'b0}}};
			div_divisor  = (acked_total_q == '0) ? 32'd1 : acked_total_q;
		end else begin
			div_dividend = {acked, {ecnfa_pkg::SEQ_W{1'b0}}};
			div_divisor  = d_pk;
		end
	end

	ecnfa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_go),
		.long_mode (cmd.div_long),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (quot)
	);

	// Shared multiplier: CE delta times per-packet bytes, or alpha >> gain_shift times window
	always_comb begin
		if (op_q == ecnfa_pkg::OP_ECN) begin
			mul_a = shr_q[ecnfa_pkg::SEQ_W-1:0];
			mul_b = {{(ecnfa_pkg::SEQ_W-ecnfa_pkg::WIN_W){1'b0}}, win_q};
		end else begin
			mul_a = d_ce;
			mul_b = quot[ecnfa_pkg::SEQ_W-1:0];
		end
		prod_c = mul_a * mul_b;
	end

	// Loss threshold and undo window
	always_comb begin
		half_win  = win_q >> 1;
		loss_wout = (half_win < ecnfa_pkg::MIN_WINDOW) ? ecnfa_pkg::MIN_WINDOW : half_win;
		undo_wout = (win_q > loss_win_q) ? win_q : loss_win_q;
	end

	// ECN window reduction, rounded, floored at the minimum window
	always_comb begin
		red_sum   = {1'b0, prod_q[51:0]} + (53'd1 << ecnfa_pkg::FRAC_BITS);
		red       = red_sum[52:32];
		red_diff  = {1'b0, win_q} - red;
		red_floor = (shr_q[ecnfa_pkg::ALPHA_W-1:ecnfa_pkg::SEQ_W] != '0)
			|| (red >= {1'b0, win_q})
			|| (red_diff < {1'b0, ecnfa_pkg::MIN_WINDOW});
		ecn_wout  = red_floor ? ecnfa_pkg::MIN_WINDOW : red_diff[ecnfa_pkg::WIN_W-1:0];
	end

	// EWMA update with saturation
	always_comb begin
		decay      = alpha_q - shr_q;
		frac       = (marked_q != '0) ? quot : '0;
		alpha_sum  = {{(ecnfa_pkg::DIV_W-ecnfa_pkg::ALPHA_W+1){1'b0}}, decay} + {1'b0, frac};
		alpha_next = (alpha_sum[ecnfa_pkg::DIV_W:ecnfa_pkg::ALPHA_W] != '0)
			? {ecnfa_pkg::ALPHA_W{1'b1}} : alpha_sum[ecnfa_pkg::ALPHA_W-1:0];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_data.operation;
			una_q <= in_data.ack_seq;
			nxt_q <= in_data.send_next;
			dlv_q <= in_data.delivered_count;
			ce_q  <= in_data.ce_count;
			win_q <= in_data.window_in;
		end
	end

	// Connection state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_ack_q   <= '0;
			base_dlv_q    <= '0;
			base_ce_q     <= '0;
			marked_q      <= '0;
			acked_total_q <= '0;
			round_end_q   <= '0;
			alpha_q       <= '0;
			loss_win_q    <= '0;
		end else begin
			if (cmd.exec) begin
				case (op_q)
					ecnfa_pkg::OP_START: begin
						prior_ack_q   <= una_q;
						alpha_q       <= '0;
						loss_win_q    <= '0;
						round_end_q   <= nxt_q;
						marked_q      <= '0;
						acked_total_q <= '0;
						base_dlv_q    <= dlv_q;
						base_ce_q     <= ce_q;
					end
					ecnfa_pkg::OP_ECN, ecnfa_pkg::OP_LOSS: begin
						loss_win_q <= win_q;
					end
					default: begin
					end
				endcase
			end
			if (cmd.acc) begin
				if (acked != '0) begin
					marked_q      <= marked_q + (mark_go ? prod_q[ecnfa_pkg::SEQ_W-1:0] : '0);
					acked_total_q <= acked_total_q + acked;
					prior_ack_q   <= una_q;
				end
				base_dlv_q <= dlv_q;
				base_ce_q  <= ce_q;
			end
			if (cmd.upd) begin
				alpha_q       <= alpha_next;
				round_end_q   <= nxt_q;
				marked_q      <= '0;
				acked_total_q <= '0;
			end
		end
	end

	// Work registers and window result
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			shr_q <= alpha_q >> gain_shift;
		end
		if (cmd.mul) begin
			prod_q <= prod_c;
		end
		if (cmd.capture) begin
			ended_q <= 1'b0;
		end else if (cmd.upd) begin
			ended_q <= 1'b1;
		end
		if (cmd.exec) begin
			case (op_q)
				ecnfa_pkg::OP_LOSS: wout_q <= loss_wout;
				ecnfa_pkg::OP_UNDO: wout_q <= undo_wout;
				default:            wout_q <= win_q;
			endcase
		end else if (cmd.red) begin
			wout_q <= ecn_wout;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.window_out  <= wout_q;
			out_q.alpha_out   <= alpha_q;
			out_q.round_ended <= ended_q;
		end
	end

	assign out_data = out_q;

	always_comb begin
		sts.op        = op_q;
		sts.mark_go   = mark_go;
		sts.round_hit = ~una_rel[ecnfa_pkg::SEQ_W-1];
		sts.marked_nz = (marked_q != '0);
		sts.div_busy  = div_busy;
	end

endmodule

[rtl/ecnfa_ctrl.sv]
// Controller: sequences one request through the datapath and owns the handshakes.
// Depends on ecnfa_pkg and the assertion macro header.
`include "ecn_fraction_alpha_estimator_unit_assert.svh"

module ecnfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ecnfa_pkg::dp_sts_t sts,
	output ecnfa_pkg::dp_cmd_t cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EXEC    = 4'd1;
	localparam logic [3:0] S_DIV_A   = 4'd2;
	localparam logic [3:0] S_MUL     = 4'd3;
	localparam logic [3:0] S_ACC     = 4'd4;
	localparam logic [3:0] S_CLOSE   = 4'd5;
	localparam logic [3:0] S_DIV_B   = 4'd6;
	localparam logic [3:0] S_UPD     = 4'd7;
	localparam logic [3:0] S_ECN_MUL = 4'd8;
	localparam logic [3:0] S_ECN_RED = 4'd9;
	localparam logic [3:0] S_FINISH  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.op)
					ecnfa_pkg::OP_ACK: begin
						if (sts.mark_go) begin
							cmd.div_go = 1'b1;
							state_d    = S_DIV_A;
						end else begin
							state_d = S_ACC;
						end
					end
					ecnfa_pkg::OP_ECN: begin
						cmd.shift = 1'b1;
						state_d   = S_ECN_MUL;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_DIV_A: begin
				if (!sts.div_busy) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.round_hit ? S_CLOSE : S_FINISH;
			end
			S_CLOSE: begin
				cmd.shift = 1'b1;
				if (sts.marked_nz) begin
					cmd.div_go   = 1'b1;
					cmd.div_long = 1'b1;
					state_d      = S_DIV_B;
				end else begin
					state_d = S_UPD;
				end
			end
			S_DIV_B: begin
				if (!sts.div_busy) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_FINISH;
			end
			S_ECN_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ECN_RED;
			end
			S_ECN_RED: begin
				cmd.red = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ECNFA_ASSERT_NEXT(a_accept_to_exec, clk, arst_n, in_valid && !in_stall, state_q == S_EXEC, "accepted request did not enter execution")
	`ECNFA_ASSERT_NOW(a_div_idle_start, clk, arst_n, cmd.div_go, !sts.div_busy, "divider restarted while busy")
	`ECNFA_ASSERT_NOW(a_load_slot_free, clk, arst_n, cmd.load_out, !out_valid_q || !out_stall, "result overwrote an untaken result")
	`ECNFA_ASSERT_NOW(a_upd_on_round_end, clk, arst_n, cmd.upd, (sts.op == ecnfa_pkg::OP_ACK) && sts.round_hit, "alpha updated outside a round end")

endmodule
